FILE: src/gbi_pkg.sv
// Package for the gate backward implication core: widths, codes, command and
// status structs shared by the controller and datapath. No dependencies.
`default_nettype none

package gbi_pkg;

   localparam int NET_COUNT = 4096;
   localparam int NET_W     = 12;
   localparam int TAG_W     = 18;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] VAL_X = 2'd2;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_ASSIGN = 2'd1;
   localparam logic [1:0] FUNC_GATE   = 2'd2;

   localparam logic [1:0] KIND_PUSH    = 2'd0;
   localparam logic [1:0] KIND_JUSTIFY = 2'd1;
   localparam logic [1:0] KIND_UNSUP   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TAG_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUSTIFY  = 1'd1;

   localparam logic [3:0] GT_INPUT  = 4'd0;
   localparam logic [3:0] GT_BUF    = 4'd1;
   localparam logic [3:0] GT_BRANCH = 4'd2;
   localparam logic [3:0] GT_INV    = 4'd3;
   localparam logic [3:0] GT_AND    = 4'd4;
   localparam logic [3:0] GT_NAND   = 4'd5;
   localparam logic [3:0] GT_OR     = 4'd6;
   localparam logic [3:0] GT_NOR    = 4'd7;
   localparam logic [3:0] GT_XOR    = 4'd8;
   localparam logic [3:0] GT_XNOR   = 4'd9;

   typedef enum logic [2:0] {
      GC_NONE, GC_COPY, GC_ANDOR, GC_XOR, GC_UNSUP
   } gclass_type;

   typedef enum logic [2:0] {
      RS_TARGET, RS_FANIN, RS_NCAND, RS_FCAND, RS_PUSH
   } rd_sel_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_CAPTURE, OP_LOAD, OP_ASSIGN, OP_LATCH, OP_FIN,
      OP_NCAND, OP_FCAND, OP_EPI, OP_END, OP_NEXT
   } op_type;

   typedef struct packed {
      op_type     op;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       first;
      logic       any_known;
      gclass_type gclass;
      logic       last;
      logic       clr_last;
      logic       push_none;
      logic       out_last;
   } status_type;

   function automatic gclass_type gate_class(input logic [3:0] gt);
      gclass_type gc;
      case (gt)
         GT_INPUT:                  gc = GC_NONE;
         GT_BUF, GT_BRANCH, GT_INV: gc = GC_COPY;
         GT_AND, GT_NAND, GT_OR, GT_NOR: gc = GC_ANDOR;
         GT_XOR, GT_XNOR:           gc = GC_XOR;
         default:                   gc = GC_UNSUP;
      endcase
      return gc;
   endfunction

endpackage

`default_nettype wire

FILE: src/gbi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gbi_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

FILE: src/gbi_ctrl.sv
// Controller state machine for the gate backward implication core.
// Depends on gbi_pkg.
`default_nettype none

module gbi_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire gbi_pkg::status_type sts,
   output gbi_pkg::cmd_type        cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_RD_TGT, S_TGT, S_CHECK, S_RD_FIN, S_FIN,
      S_RD_NC, S_NC, S_RD_FC, S_FC, S_EPI, S_END, S_RD_OUT, S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in   = state_ff;
      cmd.op     = gbi_pkg::OP_NONE;
      cmd.rd_sel = gbi_pkg::RS_PUSH;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = gbi_pkg::OP_CLEAR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = gbi_pkg::OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts.func == gbi_pkg::FUNC_LOAD) begin
               cmd.op   = gbi_pkg::OP_LOAD;
               state_in = S_IDLE;
            end else if (sts.func == gbi_pkg::FUNC_ASSIGN) begin
               cmd.op   = gbi_pkg::OP_ASSIGN;
               state_in = S_IDLE;
            end else if (sts.func == gbi_pkg::FUNC_GATE) begin
               state_in = sts.first ? S_RD_TGT : S_CHECK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD_TGT: begin
            cmd.rd_sel = gbi_pkg::RS_TARGET;
            state_in   = S_TGT;
         end
         S_TGT: begin
            cmd.op   = gbi_pkg::OP_LATCH;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.any_known) begin
               state_in = S_END;
            end else begin
               unique case (sts.gclass)
                  gbi_pkg::GC_COPY:  state_in = sts.first ? S_RD_FIN : S_END;
                  gbi_pkg::GC_ANDOR: state_in = S_RD_FIN;
                  gbi_pkg::GC_XOR:   state_in = S_RD_FIN;
                  gbi_pkg::GC_UNSUP: state_in = sts.last ? S_EPI : S_END;
                  default:           state_in = S_END;
               endcase
            end
         end
         S_RD_FIN: begin
            cmd.rd_sel = gbi_pkg::RS_FANIN;
            state_in   = S_FIN;
         end
         S_FIN: begin
            cmd.op = gbi_pkg::OP_FIN;
            if (sts.gclass == gbi_pkg::GC_ANDOR && sts.last) state_in = S_RD_NC;
            else state_in = S_END;
         end
         S_RD_NC: begin
            cmd.rd_sel = gbi_pkg::RS_NCAND;
            state_in   = S_NC;
         end
         S_NC: begin
            cmd.op   = gbi_pkg::OP_NCAND;
            state_in = S_RD_FC;
         end
         S_RD_FC: begin
            cmd.rd_sel = gbi_pkg::RS_FCAND;
            state_in   = S_FC;
         end
         S_FC: begin
            cmd.op   = gbi_pkg::OP_FCAND;
            state_in = S_EPI;
         end
         S_EPI: begin
            cmd.op   = gbi_pkg::OP_EPI;
            state_in = S_END;
         end
         S_END: begin
            cmd.op   = gbi_pkg::OP_END;
            state_in = sts.push_none ? S_IDLE : S_RD_OUT;
         end
         S_RD_OUT: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               cmd.op   = gbi_pkg::OP_NEXT;
               state_in = sts.out_last ? S_IDLE : S_RD_OUT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/gbi_datapath.sv
// Datapath: per-net tables, run state, result list and config registers.
// Depends on gbi_pkg and gbi_ram.
`default_nettype none

module gbi_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gbi_pkg::cmd_type                cmd,
   output gbi_pkg::status_type                  sts,
   input  wire logic [1:0]                      req_func,
   input  wire logic [3:0]                      req_gate_type,
   input  wire logic [gbi_pkg::NET_W-1:0]       req_target_net,
   input  wire logic [gbi_pkg::NET_W-1:0]       req_fanin_net,
   input  wire logic                            req_last_fanin,
   input  wire logic [1:0]                      req_good_value,
   input  wire logic [1:0]                      req_faulty_value,
   input  wire logic                            csr_write,
   input  wire logic [gbi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gbi_pkg::TAG_W-1:0]       csr_data,
   output logic [1:0]                           rsp_result_kind,
   output logic [gbi_pkg::NET_W-1:0]            rsp_net_id,
   output logic [1:0]                           rsp_good_out,
   output logic [1:0]                           rsp_faulty_out,
   output logic                                 rsp_last_result
);

   localparam int NW = gbi_pkg::NET_W;
   localparam int TW = gbi_pkg::TAG_W;

   logic [NW-1:0] clr_addr_ff;
   logic [1:0]    func_ff, gv_ff, fv_ff;
   logic [3:0]    type_ff;
   logic [NW-1:0] tgt_ff, fin_ff;
   logic          last_ff, first_ff;
   logic [TW-1:0] base_ff;
   logic          je_ff;
   logic          run_active_ff;
   logic [1:0]    n3v_ff, f3v_ff, ncnt_ff, fcnt_ff;
   logic          nfound_ff, ffound_ff, npushed_ff;
   logic [NW-1:0] ncand_ff, fcand_ff;
   logic [1:0]    pk_ff [4];
   logic [NW-1:0] pn_ff [4];
   logic [2:0]    pcnt_ff;
   logic [1:0]    pidx_ff;

   logic [NW-1:0] raddr, waddr;
   logic [TW-1:0] rd_tag, tag_wd, cur;
   logic          rd_ga, rd_fa, rd_gr, rd_fr;
   logic          tag_we, ga_we, fa_we, gr_we, fr_we;
   logic          ga_wd, fa_wd, gr_wd, fr_wd;
   logic [1:0]    vflg, good_rd, faulty_rd;
   logic          push_en;
   logic [1:0]    push_k;
   logic [NW-1:0] push_n;
   logic          nfound_set, ffound_set, ncand_set, fcand_set, npushed_set;
   logic          c, inv;
   logic [1:0]    tf, ts;
   logic          n_done, f_done, gs, fs;
   gbi_pkg::gclass_type gclass;

   always_comb begin
      unique case (cmd.rd_sel)
         gbi_pkg::RS_TARGET: raddr = tgt_ff;
         gbi_pkg::RS_FANIN:  raddr = fin_ff;
         gbi_pkg::RS_NCAND:  raddr = ncand_ff;
         gbi_pkg::RS_FCAND:  raddr = fcand_ff;
         default:            raddr = pn_ff[pidx_ff];
      endcase
   end

   gbi_ram #(.WIDTH(TW), .DEPTH(gbi_pkg::NET_COUNT)) u_tag (
      .clock(clock), .we(tag_we), .waddr(waddr), .wdata(tag_wd),
      .raddr(raddr), .rdata(rd_tag));
   gbi_ram #(.WIDTH(1), .DEPTH(gbi_pkg::NET_COUNT)) u_ga (
      .clock(clock), .we(ga_we), .waddr(waddr), .wdata(ga_wd),
      .raddr(raddr), .rdata(rd_ga));
   gbi_ram #(.WIDTH(1), .DEPTH(gbi_pkg::NET_COUNT)) u_fa (
      .clock(clock), .we(fa_we), .waddr(waddr), .wdata(fa_wd),
      .raddr(raddr), .rdata(rd_fa));
   gbi_ram #(.WIDTH(1), .DEPTH(gbi_pkg::NET_COUNT)) u_gr (
      .clock(clock), .we(gr_we), .waddr(waddr), .wdata(gr_wd),
      .raddr(raddr), .rdata(rd_gr));
   gbi_ram #(.WIDTH(1), .DEPTH(gbi_pkg::NET_COUNT)) u_fr (
      .clock(clock), .we(fr_we), .waddr(waddr), .wdata(fr_wd),
      .raddr(raddr), .rdata(rd_fr));

   // stale tags read as the current base; flags only count on live tags
   assign cur       = (rd_tag < base_ff) ? base_ff : rd_tag;
   assign vflg      = (rd_tag >= base_ff) ? rd_tag[1:0] : 2'b00;
   assign good_rd   = vflg[0] ? {1'b0, rd_ga} : gbi_pkg::VAL_X;
   assign faulty_rd = vflg[1] ? {1'b0, rd_fa} : gbi_pkg::VAL_X;

   assign gclass = gbi_pkg::gate_class(type_ff);
   assign c      = type_ff[1];
   assign inv    = type_ff[0];
   assign tf     = {1'b0, ~c ^ inv};
   assign ts     = {1'b0, c ^ inv};
   assign n_done = (n3v_ff != ts) || nfound_ff;
   assign f_done = (f3v_ff != ts) || ffound_ff;

   always_comb begin
      waddr = fin_ff;
      tag_we = 1'b0; ga_we = 1'b0; fa_we = 1'b0; gr_we = 1'b0; fr_we = 1'b0;
      tag_wd = cur;  ga_wd = 1'b0; fa_wd = 1'b0;
      gr_wd = gv_ff[0]; fr_wd = fv_ff[0];
      push_en = 1'b0; push_k = gbi_pkg::KIND_PUSH; push_n = fin_ff;
      nfound_set = 1'b0; ffound_set = 1'b0; ncand_set = 1'b0; fcand_set = 1'b0;
      npushed_set = 1'b0;
      gs = 1'b0; fs = 1'b0;
      unique case (cmd.op)
         gbi_pkg::OP_CLEAR: begin
            waddr = clr_addr_ff;
            tag_we = 1'b1; ga_we = 1'b1; fa_we = 1'b1;
            tag_wd = '0;
         end
         gbi_pkg::OP_LOAD: begin
            waddr = tgt_ff;
            gr_we = ~gv_ff[1];
            fr_we = ~fv_ff[1];
         end
         gbi_pkg::OP_ASSIGN: begin
            waddr  = tgt_ff;
            tag_we = 1'b1;
            tag_wd = base_ff | {{(TW-2){1'b0}}, ~fv_ff[1], ~gv_ff[1]};
            ga_we  = ~gv_ff[1]; ga_wd = gv_ff[0];
            fa_we  = ~fv_ff[1]; fa_wd = fv_ff[0];
         end
         gbi_pkg::OP_FIN: begin
            priority if (gclass == gbi_pkg::GC_COPY) begin
               gs    = (n3v_ff != gbi_pkg::VAL_X) && !cur[0];
               fs    = (f3v_ff != gbi_pkg::VAL_X) && !cur[1];
               ga_wd = n3v_ff[0] ^ (type_ff == gbi_pkg::GT_INV);
               fa_wd = f3v_ff[0] ^ (type_ff == gbi_pkg::GT_INV);
            end else if (gclass == gbi_pkg::GC_XOR) begin
               gs    = !cur[0];
               fs    = !cur[1];
               ga_wd = rd_gr;
               fa_wd = rd_fr;
            end else begin
               ga_wd = ~c;
               fa_wd = ~c;
               if (n3v_ff == tf) begin
                  gs = !cur[0];
               end else if (n3v_ff == ts) begin
                  if (cur[0]) nfound_set = (rd_ga == c);
                  else ncand_set = (rd_gr == c);
               end
               if (f3v_ff == tf) begin
                  fs = !cur[1];
               end else if (f3v_ff == ts) begin
                  if (cur[1]) ffound_set = (rd_fa == c);
                  else fcand_set = (rd_fr == c);
               end
            end
            ga_we   = gs;
            fa_we   = fs;
            tag_we  = gs | fs;
            tag_wd  = cur | {{(TW-2){1'b0}}, fs, gs};
            push_en = gs | fs;
         end
         gbi_pkg::OP_NCAND: begin
            waddr = ncand_ff;
            if (!n_done && ncnt_ff == 2'd1 && !cur[0]) begin
               ga_we = 1'b1; ga_wd = c;
               tag_we = 1'b1; tag_wd = cur | {{(TW-1){1'b0}}, 1'b1};
               push_en = 1'b1; push_n = ncand_ff;
               npushed_set = 1'b1;
            end
         end
         gbi_pkg::OP_FCAND: begin
            waddr = fcand_ff;
            if (!f_done && fcnt_ff == 2'd1 && !cur[1]) begin
               fa_we = 1'b1; fa_wd = c;
               tag_we = 1'b1; tag_wd = cur | {{(TW-2){1'b0}}, 2'b10};
               push_en = !(npushed_ff && fcand_ff == ncand_ff);
               push_n = fcand_ff;
            end
         end
         gbi_pkg::OP_EPI: begin
            push_n = tgt_ff;
            if (gclass == gbi_pkg::GC_UNSUP) begin
               push_en = 1'b1;
               push_k  = gbi_pkg::KIND_UNSUP;
            end else begin
               push_k  = gbi_pkg::KIND_JUSTIFY;
               push_en = je_ff && ((!n_done && ncnt_ff == 2'd2) ||
                                   (!f_done && fcnt_ff == 2'd2));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         base_ff       <= '0;
         je_ff         <= 1'b1;
         run_active_ff <= 1'b0;
         n3v_ff        <= gbi_pkg::VAL_X;
         f3v_ff        <= gbi_pkg::VAL_X;
         nfound_ff     <= 1'b0;
         ffound_ff     <= 1'b0;
         ncnt_ff       <= '0;
         fcnt_ff       <= '0;
         ncand_ff      <= '0;
         fcand_ff      <= '0;
         npushed_ff    <= 1'b0;
         pcnt_ff       <= '0;
         pidx_ff       <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == gbi_pkg::CSR_TAG_BASE) base_ff <= csr_data;
            if (csr_index == gbi_pkg::CSR_JUSTIFY) je_ff <= csr_data[0];
         end
         if (cmd.op == gbi_pkg::OP_CLEAR) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (cmd.op == gbi_pkg::OP_CAPTURE) begin
            first_ff   <= !run_active_ff;
            pcnt_ff    <= '0;
            pidx_ff    <= '0;
            npushed_ff <= 1'b0;
         end
         if (cmd.op == gbi_pkg::OP_LATCH) begin
            n3v_ff        <= good_rd;
            f3v_ff        <= faulty_rd;
            nfound_ff     <= 1'b0;
            ffound_ff     <= 1'b0;
            ncnt_ff       <= '0;
            fcnt_ff       <= '0;
            ncand_ff      <= '0;
            fcand_ff      <= '0;
            run_active_ff <= 1'b1;
         end
         if (nfound_set) nfound_ff <= 1'b1;
         if (ffound_set) ffound_ff <= 1'b1;
         if (ncand_set) begin
            ncand_ff <= fin_ff;
            if (ncnt_ff != 2'd2) ncnt_ff <= ncnt_ff + 2'd1;
         end
         if (fcand_set) begin
            fcand_ff <= fin_ff;
            if (fcnt_ff != 2'd2) fcnt_ff <= fcnt_ff + 2'd1;
         end
         if (npushed_set) npushed_ff <= 1'b1;
         if (push_en && pcnt_ff != 3'd4) pcnt_ff <= pcnt_ff + 3'd1;
         if (cmd.op == gbi_pkg::OP_END && last_ff) run_active_ff <= 1'b0;
         if (cmd.op == gbi_pkg::OP_NEXT) pidx_ff <= pidx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == gbi_pkg::OP_CAPTURE) begin
         func_ff <= req_func;
         type_ff <= req_gate_type;
         tgt_ff  <= req_target_net;
         fin_ff  <= req_fanin_net;
         last_ff <= req_last_fanin;
         gv_ff   <= req_good_value;
         fv_ff   <= req_faulty_value;
      end
      if (push_en && pcnt_ff != 3'd4) begin
         pk_ff[pcnt_ff[1:0]] <= push_k;
         pn_ff[pcnt_ff[1:0]] <= push_n;
      end
   end

   assign sts.func      = func_ff;
   assign sts.first     = first_ff;
   assign sts.any_known = (n3v_ff != gbi_pkg::VAL_X) || (f3v_ff != gbi_pkg::VAL_X);
   assign sts.gclass    = gclass;
   assign sts.last      = last_ff;
   assign sts.clr_last  = (clr_addr_ff == {NW{1'b1}});
   assign sts.push_none = (pcnt_ff == 3'd0);
   assign sts.out_last  = ({1'b0, pidx_ff} + 3'd1 == pcnt_ff);

   assign rsp_result_kind = pk_ff[pidx_ff];
   assign rsp_net_id      = pn_ff[pidx_ff];
   assign rsp_good_out    = good_rd;
   assign rsp_faulty_out  = faulty_rd;
   assign rsp_last_result = sts.out_last;

endmodule

`default_nettype wire

FILE: src/gate_backward_implication_core.sv
// Top level of the gate backward implication core: controller plus datapath.
// Depends on gbi_pkg, gbi_ctrl, gbi_datapath.
//
//  channel  signals                          direction
//  req      req_valid/req_stall + fields     in  (one transaction per item)
//  rsp      rsp_valid/rsp_stall + fields     out (up to 4 transactions per item)
//  csr      csr_valid/csr_ready, index, data in  (register writes)
//
// A gate element runs the table read-modify-write sequence (target read,
// fan-in, two candidates) and then returns its results. One item is in work
// at a time.
// After reset a clearing pass runs over all 4096 net table entries; req stays
// stalled until it ends. A stalled rsp holds the block until taken.
`default_nettype none

module gate_backward_implication_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_func,
   input  wire logic [3:0]                    req_gate_type,
   input  wire logic [gbi_pkg::NET_W-1:0]     req_target_net,
   input  wire logic [gbi_pkg::NET_W-1:0]     req_fanin_net,
   input  wire logic                          req_last_fanin,
   input  wire logic [1:0]                    req_good_value,
   input  wire logic [1:0]                    req_faulty_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_result_kind,
   output logic [gbi_pkg::NET_W-1:0]          rsp_net_id,
   output logic [1:0]                         rsp_good_out,
   output logic [1:0]                         rsp_faulty_out,
   output logic                               rsp_last_result,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [gbi_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gbi_pkg::TAG_W-1:0]     csr_data
);

   gbi_pkg::cmd_type    cmd;
   gbi_pkg::status_type sts;

   assign csr_ready = 1'b1;

   gbi_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd));

   gbi_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_func(req_func), .req_gate_type(req_gate_type),
      .req_target_net(req_target_net), .req_fanin_net(req_fanin_net),
      .req_last_fanin(req_last_fanin), .req_good_value(req_good_value),
      .req_faulty_value(req_faulty_value),
      .csr_write(csr_valid & csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_result_kind(rsp_result_kind), .rsp_net_id(rsp_net_id),
      .rsp_good_out(rsp_good_out), .rsp_faulty_out(rsp_faulty_out),
      .rsp_last_result(rsp_last_result));

endmodule

`default_nettype wire

FILE: src/gbi_checker.sv
// Port-level checker for gate_backward_implication_core, with its bind.
// Depends on gbi_pkg.
`default_nettype none

module gbi_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [1:0]                rsp_result_kind,
   input wire logic [gbi_pkg::NET_W-1:0] rsp_net_id,
   input wire logic [1:0]                rsp_good_out,
   input wire logic [1:0]                rsp_faulty_out,
   input wire logic                      rsp_last_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_net_id))
      else $error("rsp dropped or changed while stalled");

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req taken while results pending");

   a_push_has_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == gbi_pkg::KIND_PUSH |->
         rsp_good_out != gbi_pkg::VAL_X || rsp_faulty_out != gbi_pkg::VAL_X)
      else $error("pushed net has no assigned value");

   a_unsup_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == gbi_pkg::KIND_UNSUP |-> rsp_last_result)
      else $error("unsupported-gate transaction not last");

endmodule

bind gate_backward_implication_core gbi_checker u_gbi_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_result_kind(rsp_result_kind), .rsp_net_id(rsp_net_id),
   .rsp_good_out(rsp_good_out), .rsp_faulty_out(rsp_faulty_out),
   .rsp_last_result(rsp_last_result));

`default_nettype wire
